FILE: sv/fpsc_pkg.sv
// Shared types, widths and helpers for the four-wheel PID speed controller.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package fpsc_pkg;

  // Widths of the fixed fields
  localparam int SPEED_W = 16;
  localparam int ERR_W   = SPEED_W + 1;
  localparam int DIFF_W  = ERR_W + 1;
  localparam int GAIN_W  = 32;
  localparam int FRAC_W  = 16;
  localparam int DRIVE_W = 8;
  localparam int LANES   = 4;

  // Error sum width and its split for the two partial products
  localparam int SUM_BITS = 48;
  localparam int SUM_LO_W = SUM_BITS / 2;
  localparam int SUM_HI_W = SUM_BITS - SUM_LO_W;

  // Product and accumulator widths
  localparam int PKP_W = ERR_W + GAIN_W;
  localparam int PKD_W = DIFF_W + GAIN_W;
  localparam int PLO_W = SUM_LO_W + 1 + GAIN_W;
  localparam int PHI_W = SUM_HI_W + GAIN_W;
  localparam int ACC_W = SUM_BITS + GAIN_W + 2;
  localparam int MAG_W = ACC_W - FRAC_W;

  // Pipeline depth inside a lane (operand, product, partial sum, sum, magnitude)
  localparam int STAGES = 5;

  localparam logic [DRIVE_W-2:0] DRIVE_LIMIT = 7'd100;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_KP     = 2'd0,
    REG_KI     = 2'd1,
    REG_KD     = 2'd2,
    REG_TIMING = 2'd3
  } fpsc_reg_e;

  // Per-stage load strobes from the pipeline control
  typedef struct packed {
    logic [STAGES:1] stage;
    logic            out;
  } fpsc_adv_t;

  // Clamp a truncated magnitude to the drive limit and restore the sign
  function automatic logic signed [DRIVE_W-1:0] fpsc_clamp(
    input logic [MAG_W-1:0] mag,
    input logic             neg
  );
    logic [DRIVE_W-2:0] lim;
    lim = (mag > MAG_W'(DRIVE_LIMIT)) ? DRIVE_LIMIT : mag[DRIVE_W-2:0];
    return neg ? -$signed({1'b0, lim}) : $signed({1'b0, lim});
  endfunction

endpackage

FILE: sv/fpsc_if.sv
// Valid/ready channel interfaces for the tick input and the drive result.
// Depends on fpsc_pkg for field widths.
`timescale 1ns / 1ps

interface fpsc_in_if;
  import fpsc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SPEED_W-1:0]  target_front_left;
  logic signed [SPEED_W-1:0]  target_front_right;
  logic signed [SPEED_W-1:0]  target_rear_left;
  logic signed [SPEED_W-1:0]  target_rear_right;
  logic signed [SPEED_W-1:0]  measured_front_left;
  logic signed [SPEED_W-1:0]  measured_front_right;
  logic signed [SPEED_W-1:0]  measured_rear_left;
  logic signed [SPEED_W-1:0]  measured_rear_right;
  logic                       sensors_valid;

  modport source (
    output valid, target_front_left, target_front_right, target_rear_left,
           target_rear_right, measured_front_left, measured_front_right,
           measured_rear_left, measured_rear_right, sensors_valid,
    input  ready
  );

  modport sink (
    input  valid, target_front_left, target_front_right, target_rear_left,
           target_rear_right, measured_front_left, measured_front_right,
           measured_rear_left, measured_rear_right, sensors_valid,
    output ready
  );
endinterface

interface fpsc_out_if;
  import fpsc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [DRIVE_W-1:0]  drive_front_left;
  logic signed [DRIVE_W-1:0]  drive_front_right;
  logic signed [DRIVE_W-1:0]  drive_rear_left;
  logic signed [DRIVE_W-1:0]  drive_rear_right;

  modport source (
    output valid, drive_front_left, drive_front_right, drive_rear_left,
           drive_rear_right,
    input  ready
  );

  modport sink (
    input  valid, drive_front_left, drive_front_right, drive_rear_left,
           drive_rear_right,
    output ready
  );
endinterface

FILE: sv/fpsc_pipe_ctrl.sv
// Valid tracking and per-stage load strobes for the lane pipelines.
// Depends on fpsc_pkg (STAGES, fpsc_adv_t).
`timescale 1ns / 1ps

module fpsc_pipe_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fpsc_pkg::fpsc_adv_t adv_o
);
  import fpsc_pkg::*;

  logic [STAGES:1] vld_q, vld_d;
  logic            out_vld_q, out_vld_d;
  fpsc_adv_t       adv;

  // A stage may load when it is empty or its content moves on
  always_comb begin
    adv.out = !out_vld_q || out_ready_i;
    adv.stage[STAGES] = !vld_q[STAGES] || adv.out;
    for (int k = STAGES - 1; k >= 1; k--) begin
      adv.stage[k] = !vld_q[k] || adv.stage[k+1];
    end
  end

  // Advance valid bits along the pipeline
  always_comb begin
    vld_d = vld_q;
    out_vld_d = adv.out ? vld_q[STAGES] : out_vld_q;
    vld_d[1] = adv.stage[1] ? in_valid_i : vld_q[1];
    for (int k = 2; k <= STAGES; k++) begin
      if (adv.stage[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      vld_q     <= vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign in_ready_o  = adv.stage[1];
  assign out_valid_o = out_vld_q;
  assign adv_o       = adv;

endmodule

FILE: sv/fpsc_lane.sv
// One wheel's PID lane: error state update, gain products, sum and magnitude.
// Depends on fpsc_pkg; load strobes come from fpsc_pipe_ctrl.
`timescale 1ns / 1ps

module fpsc_lane (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  fpsc_pkg::fpsc_adv_t              adv_i,
  input  logic                             accept_i,
  input  logic                             sensors_valid_i,
  input  logic                             timing_i,
  input  logic signed [fpsc_pkg::GAIN_W-1:0]  kp_i,
  input  logic signed [fpsc_pkg::GAIN_W-1:0]  ki_i,
  input  logic signed [fpsc_pkg::GAIN_W-1:0]  kd_i,
  input  logic signed [fpsc_pkg::SPEED_W-1:0] target_i,
  input  logic signed [fpsc_pkg::SPEED_W-1:0] measured_i,
  output logic [fpsc_pkg::MAG_W-1:0]       mag_o,
  output logic                             neg_o
);
  import fpsc_pkg::*;

  localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

  // Wheel state
  logic signed [SUM_BITS-1:0] sum_q;
  logic signed [ERR_W-1:0]    last_q;

  // Stage 1 operands
  logic signed [ERR_W-1:0]    err;
  logic signed [SUM_BITS:0]   sum_ext;
  logic signed [SUM_BITS-1:0] sum_sat;
  logic signed [DIFF_W-1:0]   diff;
  logic                       use_id;
  logic signed [ERR_W-1:0]    op_err_q;
  logic signed [SUM_BITS-1:0] op_sum_q;
  logic signed [DIFF_W-1:0]   op_diff_q;

  // Stage 2 products
  logic signed [PKP_W-1:0] p_kp_q;
  logic signed [PKD_W-1:0] p_kd_q;
  logic signed [PLO_W-1:0] p_lo_q;
  logic signed [PHI_W-1:0] p_hi_q;

  // Stage 3 and 4 sums
  logic signed [ACC_W-1:0] pa_q, pb_q, acc_q;
  logic [ACC_W-1:0]        mag_full;
  logic [MAG_W-1:0]        mag_q;
  logic                    neg_q;

  // Error, saturating sum and difference
  always_comb begin
    err     = ERR_W'(target_i) - ERR_W'(measured_i);
    sum_ext = (SUM_BITS+1)'(sum_q) + (SUM_BITS+1)'(err);
    if (sum_ext[SUM_BITS] != sum_ext[SUM_BITS-1]) begin
      sum_sat = sum_ext[SUM_BITS] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_ext[SUM_BITS-1:0];
    end
    diff   = DIFF_W'(err) - DIFF_W'(last_q);
    use_id = sensors_valid_i && timing_i;
  end

  // Update wheel state on an accepted tick with good sensors; the sum only with timing on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      last_q <= '0;
    end else if (accept_i && sensors_valid_i) begin
      last_q <= err;
      if (timing_i) begin
        sum_q <= sum_sat;
      end
    end
  end

  // Zeroed operands give a zero drive for bad sensors and drop I and D terms
  always_ff @(posedge clk_i) begin
    if (adv_i.stage[1]) begin
      op_err_q  <= sensors_valid_i ? err : '0;
      op_sum_q  <= use_id ? sum_sat : '0;
      op_diff_q <= use_id ? diff : '0;
    end
  end

  // Gain products, the sum term split in two halves
  always_ff @(posedge clk_i) begin
    if (adv_i.stage[2]) begin
      p_kp_q <= op_err_q * kp_i;
      p_kd_q <= op_diff_q * kd_i;
      p_lo_q <= $signed({1'b0, op_sum_q[SUM_LO_W-1:0]}) * ki_i;
      p_hi_q <= $signed(op_sum_q[SUM_BITS-1:SUM_LO_W]) * ki_i;
    end
  end

  // Partial sums
  always_ff @(posedge clk_i) begin
    if (adv_i.stage[3]) begin
      pa_q <= ACC_W'(p_kp_q) + ACC_W'(p_kd_q);
      pb_q <= (ACC_W'(p_hi_q) <<< SUM_LO_W) + ACC_W'(p_lo_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.stage[4]) begin
      acc_q <= pa_q + pb_q;
    end
  end

  // Magnitude truncated toward zero
  assign mag_full = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);

  always_ff @(posedge clk_i) begin
    if (adv_i.stage[5]) begin
      mag_q <= mag_full[ACC_W-1:FRAC_W];
      neg_q <= acc_q[ACC_W-1];
    end
  end

  assign mag_o = mag_q;
  assign neg_o = neg_q;

endmodule

FILE: sv/four_wheel_pid_speed_control_top.sv
// Top level: configuration registers, four wheel lanes and the merged result.
// Depends on fpsc_pkg, fpsc_if, fpsc_pipe_ctrl and fpsc_lane.
`timescale 1ns / 1ps

// Four-wheel PID speed controller. Its four wheels run in four parallel
// lanes; the drive result passes the operand, product, two sum and
// magnitude stages and the clamping output register. A tick is taken every
// cycle, limited only by the output handshake. Gains and the timing enable
// are written through cfg_we_i / cfg_idx_i / cfg_data_i; the user must do so
// only while no tick is in flight, which the block itself does not enforce.
module four_wheel_pid_speed_control_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_idx_i,
  input  logic [fpsc_pkg::GAIN_W-1:0]     cfg_data_i,
  fpsc_in_if.sink                         in_i,
  fpsc_out_if.source                      out_o
);
  import fpsc_pkg::*;

  logic signed [GAIN_W-1:0]  kp_q, ki_q, kd_q;
  logic                      timing_q;
  fpsc_adv_t                 adv;
  logic                      accept;
  logic signed [SPEED_W-1:0] tgt [LANES];
  logic signed [SPEED_W-1:0] meas [LANES];
  logic [MAG_W-1:0]          mag [LANES];
  logic                      neg [LANES];
  logic signed [DRIVE_W-1:0] drive_q [LANES];

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q     <= '0;
      ki_q     <= '0;
      kd_q     <= '0;
      timing_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (fpsc_reg_e'(cfg_idx_i))
        REG_KP:     kp_q     <= cfg_data_i;
        REG_KI:     ki_q     <= cfg_data_i;
        REG_KD:     kd_q     <= cfg_data_i;
        REG_TIMING: timing_q <= cfg_data_i[0];
        default:    ;
      endcase
    end
  end

  fpsc_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .adv_o       (adv)
  );

  assign accept = in_i.valid && adv.stage[1];

  // Wheel order: front left, front right, rear left, rear right
  assign tgt[0]  = in_i.target_front_left;
  assign tgt[1]  = in_i.target_front_right;
  assign tgt[2]  = in_i.target_rear_left;
  assign tgt[3]  = in_i.target_rear_right;
  assign meas[0] = in_i.measured_front_left;
  assign meas[1] = in_i.measured_front_right;
  assign meas[2] = in_i.measured_rear_left;
  assign meas[3] = in_i.measured_rear_right;

  for (genvar w = 0; w < LANES; w++) begin : g_lane
    fpsc_lane u_lane (
      .clk_i           (clk_i),
      .rst_ni          (rst_ni),
      .adv_i           (adv),
      .accept_i        (accept),
      .sensors_valid_i (in_i.sensors_valid),
      .timing_i        (timing_q),
      .kp_i            (kp_q),
      .ki_i            (ki_q),
      .kd_i            (kd_q),
      .target_i        (tgt[w]),
      .measured_i      (meas[w]),
      .mag_o           (mag[w]),
      .neg_o           (neg[w])
    );
  end

  // Clamp each lane and hold the merged result until its transfer
  always_ff @(posedge clk_i) begin
    if (adv.out) begin
      for (int w = 0; w < LANES; w++) begin
        drive_q[w] <= fpsc_clamp(mag[w], neg[w]);
      end
    end
  end

  assign out_o.drive_front_left  = drive_q[0];
  assign out_o.drive_front_right = drive_q[1];
  assign out_o.drive_rear_left   = drive_q[2];
  assign out_o.drive_rear_right  = drive_q[3];

endmodule
